FILE: rtl/hc3_pkg.sv
// hc3_pkg: shared types, constants and mod-26 helpers for the 3x3 hill cipher block
// no dependencies; imported by every other file in rtl

package hc3_pkg;

    localparam int DIM      = 3;
    localparam int MODULUS  = 26;
    localparam int LET_W    = 5;
    localparam int KEY_N    = DIM * DIM;
    localparam int KEY_W    = KEY_N * LET_W;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int DER_LAT  = 4;
    localparam int DCNT_W   = $clog2(DER_LAT + 1);
    localparam int PROD_W   = 2 * LET_W;
    localparam int COF_W    = PROD_W + 1;
    localparam int DET_W    = COF_W + LET_W + 2;
    localparam int SUM_W    = PROD_W + 2;
    localparam int RED_W    = 20;

    typedef logic [LET_W-1:0]       t_let;
    typedef t_let [KEY_N-1:0]       t_mat;
    typedef logic [PROD_W-1:0]      t_prod;
    typedef logic signed [COF_W-1:0] t_cof;

    typedef enum logic {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        t_let [DIM-1:0]   ltr;
    } t_item;

    typedef struct packed {
        logic ready;
        logic ok;
    } t_keyinfo;

    // signed value into 0..25; quotient by reciprocal, valid for |v| < 2**19
    function automatic t_let red26(input logic signed [RED_W-1:0] v);
        logic [RED_W-1:0]     a;
        logic [RED_W+14:0]    p;
        logic [RED_W-1:0]     q;
        logic [RED_W-1:0]     r;
        a = v[RED_W-1] ? RED_W'(-v) : RED_W'(v);
        p = a * 15'd20164;
        q = RED_W'(p >> 19);
        r = a - RED_W'(q * RED_W'(MODULUS));
        if (r >= RED_W'(MODULUS)) begin
            r = r - RED_W'(MODULUS);
        end
        if (v[RED_W-1] && (r != '0)) begin
            r = RED_W'(MODULUS) - r;
        end
        return r[LET_W-1:0];
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic t_let inv26(input t_let d);
        t_let k;
        case (d)
            5'd1:    k = 5'd1;
            5'd3:    k = 5'd9;
            5'd5:    k = 5'd21;
            5'd7:    k = 5'd15;
            5'd9:    k = 5'd3;
            5'd11:   k = 5'd19;
            5'd15:   k = 5'd7;
            5'd17:   k = 5'd23;
            5'd19:   k = 5'd11;
            5'd21:   k = 5'd5;
            5'd23:   k = 5'd17;
            5'd25:   k = 5'd25;
            default: k = 5'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/hc3_if.sv
// hc3_if: valid/ready channel interfaces for letter blocks and results
// depends on hc3_pkg

interface hc3_in_if;
    import hc3_pkg::*;
    logic valid;
    logic ready;
    logic command;
    t_let letter_a;
    t_let letter_b;
    t_let letter_c;

    modport source (output valid, command, letter_a, letter_b, letter_c, input ready);
    modport sink   (input valid, command, letter_a, letter_b, letter_c, output ready);
endinterface

interface hc3_out_if;
    import hc3_pkg::*;
    logic valid;
    logic ready;
    t_let out_a;
    t_let out_b;
    t_let out_c;
    logic status;

    modport source (output valid, out_a, out_b, out_c, status, input ready);
    modport sink   (input valid, out_a, out_b, out_c, status, output ready);
endinterface

FILE: rtl/hill_cipher_3x3_mod26.sv
// hill_cipher_3x3_mod26: top level of the 3x3 hill cipher engine
// depends on hc3_pkg, hc3_if, hc3_front, hc3_queue, hc3_keygen, hc3_back
//
// usage:
//   i_blk  carries one block of three letters plus a command (0 encrypt, 1 decrypt);
//          a transaction is valid and ready high at a rising edge
//   o_res  returns one result per block in order: three letters and a status;
//          status 1 means decrypt with a key not invertible mod 26, letters are then 0
//   i_cfg_we / i_cfg_wdata load the 45-bit key, nine 5-bit entries row-major,
//          entry 0 in the low bits; write only while no block is in flight
// latency: a block accepted at one edge shows on o_res three edges later
// throughput: one block per cycle, set by the pipelined multiply and reduce stages
// key derivation: the inverse key is built over four cycles after reset or a key
//   write; blocks are accepted during that time and wait in the queue
// reset: synchronous active low; key goes to 0, queue and pipeline empty
// stall: when o_res is held off, the back part stops, the two-entry queue fills,
//   then the input register holds and i_blk.ready drops

module hill_cipher_3x3_mod26 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hc3_in_if.sink                     i_blk,
    hc3_out_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [hc3_pkg::KEY_W-1:0]  i_cfg_wdata
);
    import hc3_pkg::*;

    logic      w_push;
    t_item     w_f_item;
    logic      w_q_ready;
    logic      w_q_valid;
    t_item     w_q_item;
    logic      w_pop;
    t_mat      w_key;
    t_mat      w_inv;
    t_keyinfo  w_info;

    hc3_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_blk     (i_blk),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_f_item)
    );

    hc3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    hc3_keygen u_keygen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_key       (w_key),
        .o_inv       (w_inv),
        .o_info      (w_info)
    );

    hc3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .i_key     (w_key),
        .i_inv     (w_inv),
        .i_info    (w_info),
        .o_res     (o_res)
    );

    // no block leaves the queue while the inverse key is still settling
    a_pop_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_info.ready && w_q_valid)
        else $error("queue popped before key derivation settled");

    a_cfg_restarts_derivation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !w_info.ready)
        else $error("key write did not restart derivation");

    a_status_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status |->
            o_res.out_a == '0 && o_res.out_b == '0 && o_res.out_c == '0)
        else $error("failed decrypt with nonzero letters");

    a_letters_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.out_a < LET_W'(MODULUS) && o_res.out_b < LET_W'(MODULUS)
                        && o_res.out_c < LET_W'(MODULUS))
        else $error("result letter outside 0..25");

endmodule

FILE: rtl/hc3_front.sv
// hc3_front: input register stage, decodes the command and pushes into the queue
// depends on hc3_pkg, hc3_if

module hc3_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hc3_in_if.sink          i_blk,
    input  logic            i_q_ready,
    output logic            o_push,
    output hc3_pkg::t_item  o_item
);
    import hc3_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    assign i_blk.ready = !r_vld || i_q_ready;
    assign o_push      = r_vld && i_q_ready;
    assign o_item      = r_item;

    always_comb begin
        n_item.op     = i_blk.command ? OP_DEC : OP_ENC;
        n_item.ltr[0] = i_blk.letter_a;
        n_item.ltr[1] = i_blk.letter_b;
        n_item.ltr[2] = i_blk.letter_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_blk.ready) begin
            r_vld <= i_blk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_blk.valid && i_blk.ready) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/hc3_queue.sv
// hc3_queue: short register queue between the front and back parts
// depends on hc3_pkg

module hc3_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hc3_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_pop,
    output hc3_pkg::t_item  o_item
);
    import hc3_pkg::*;

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;

    assign o_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: rtl/hc3_keygen.sv
// hc3_keygen: key register and the staged derivation of the inverse key mod 26
// depends on hc3_pkg

module hc3_keygen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hc3_pkg::KEY_W-1:0]     i_cfg_wdata,
    output hc3_pkg::t_mat                 o_key,
    output hc3_pkg::t_mat                 o_inv,
    output hc3_pkg::t_keyinfo             o_info
);
    import hc3_pkg::*;

    logic [KEY_W-1:0]    r_key;
    t_mat                w_k;
    t_cof                r_cof  [KEY_N];
    t_cof                n_cof  [KEY_N];
    t_let                r_cofr [KEY_N];
    logic signed [DET_W-1:0] r_det;
    logic signed [DET_W-1:0] n_det;
    t_let                r_kinv;
    t_mat                r_inv;
    logic                r_ok;
    logic [DCNT_W-1:0]   r_cnt;

    assign w_k         = r_key;
    assign o_key       = w_k;
    assign o_inv       = r_inv;
    assign o_info.ready = r_cnt == DCNT_W'(DER_LAT);
    assign o_info.ok    = r_ok;

    // signed cofactors from the cyclic form of the 3x3 minors
    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                n_cof[i*DIM+j] =
                    $signed({1'b0, t_prod'(w_k[((i+1)%DIM)*DIM + (j+1)%DIM]
                                         * w_k[((i+2)%DIM)*DIM + (j+2)%DIM])})
                  - $signed({1'b0, t_prod'(w_k[((i+1)%DIM)*DIM + (j+2)%DIM]
                                         * w_k[((i+2)%DIM)*DIM + (j+1)%DIM])});
            end
        end
    end

    always_comb begin
        n_det = '0;
        for (int f = 0; f < DIM; f++) begin
            n_det = n_det + $signed({1'b0, w_k[f]}) * r_cof[f];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_wdata;
        end
    end

    // settle count restarts on every key write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_cnt <= '0;
        end else if (r_cnt != DCNT_W'(DER_LAT)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < KEY_N; k++) begin
            r_cof[k]  <= n_cof[k];
            r_cofr[k] <= red26(RED_W'(r_cof[k]));
        end
        r_det  <= n_det;
        r_kinv <= inv26(red26(RED_W'(r_det)));
        r_ok   <= r_kinv != '0;
        // inverse is the transposed cofactor matrix scaled by the det inverse
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                r_inv[j*DIM+i] <= red26(RED_W'(t_prod'(r_cofr[i*DIM+j] * r_kinv)));
            end
        end
    end

endmodule

FILE: rtl/hc3_back.sv
// hc3_back: matrix-vector multiply mod 26 with a registered result stage
// depends on hc3_pkg, hc3_if

module hc3_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  hc3_pkg::t_item     i_q_item,
    output logic               o_pop,
    input  hc3_pkg::t_mat      i_key,
    input  hc3_pkg::t_mat      i_inv,
    input  hc3_pkg::t_keyinfo  i_info,
    hc3_out_if.source          o_res
);
    import hc3_pkg::*;

    logic              w_en;
    t_mat              w_mat;
    logic              r_a_vld;
    logic              r_a_err;
    t_prod             r_a_prod [KEY_N];
    logic              r_o_vld;
    t_let              r_o_let [DIM];
    logic              r_o_err;
    logic [SUM_W-1:0]  n_sum [DIM];

    assign w_en  = !r_o_vld || o_res.ready;
    assign o_pop = w_en && i_q_valid && i_info.ready;
    assign w_mat = (i_q_item.op == OP_DEC) ? i_inv : i_key;

    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            n_sum[i] = '0;
            for (int j = 0; j < DIM; j++) begin
                n_sum[i] = n_sum[i] + SUM_W'(r_a_prod[i*DIM+j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= o_pop;
            r_o_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_err <= (i_q_item.op == OP_DEC) && !i_info.ok;
            for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                    r_a_prod[i*DIM+j] <= w_mat[i*DIM+j] * i_q_item.ltr[j];
                end
            end
            r_o_err <= r_a_err;
            for (int i = 0; i < DIM; i++) begin
                r_o_let[i] <= r_a_err ? '0 : red26(RED_W'(n_sum[i]));
            end
        end
    end

    assign o_res.valid  = r_o_vld;
    assign o_res.out_a  = r_o_let[0];
    assign o_res.out_b  = r_o_let[1];
    assign o_res.out_c  = r_o_let[2];
    assign o_res.status = r_o_err;

endmodule
